// File: rtl/core/vne_pkg.sv
// Shared types, constants and the neighbor offset table for the volume
// neighborhood extractor. No dependencies.
package vne_pkg;

  localparam int MAX_DIM     = 32;
  localparam int COORD_W     = $clog2(MAX_DIM);
  localparam int EXT_W       = COORD_W + 1;
  localparam int ADDR_W      = 3 * COORD_W;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int VAL_W       = 64;
  localparam int NBR_COUNT   = 26;
  localparam int IDX_W       = 5;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_OUTSIDE = 2'd2
  } cmd_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXTENT_X = 2'd0,
    CFG_EXTENT_Y = 2'd1,
    CFG_EXTENT_Z = 2'd2
  } cfg_reg_t;

  // Saturated extents, each at most MAX_DIM.
  typedef struct packed {
    logic [EXT_W-1:0] x;
    logic [EXT_W-1:0] y;
    logic [EXT_W-1:0] z;
  } extents_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [VAL_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic             last;
    logic             oor;
  } result_t;

  // Offsets are stored biased by one: 0, 1, 2 stand for -1, 0, +1.
  typedef struct packed {
    logic [1:0] dx;
    logic [1:0] dy;
    logic [1:0] dz;
  } offset_t;

  typedef offset_t [NBR_COUNT-1:0] offset_table_t;

  // Walks the 3x3x3 cube with x fastest and drops the center.
  function automatic offset_table_t build_offsets();
    offset_table_t tbl;
    int            n;
    tbl = '0;
    n   = 0;
    for (int z = 0; z < 3; z++) begin
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          if (!(x == 1 && y == 1 && z == 1)) begin
            tbl[n].dx = 2'(x);
            tbl[n].dy = 2'(y);
            tbl[n].dz = 2'(z);
            n++;
          end
        end
      end
    end
    return tbl;
  endfunction

  localparam offset_table_t NBR_OFFSETS = build_offsets();

endpackage

// File: rtl/core/vne_front.sv
// Front end: accepts input transactions and classifies them into commands.
// Depends on vne_pkg.
module vne_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [vne_pkg::COORD_W-1:0] in_pos_x,
  input  logic [vne_pkg::COORD_W-1:0] in_pos_y,
  input  logic [vne_pkg::COORD_W-1:0] in_pos_z,
  input  logic [vne_pkg::VAL_W-1:0]   in_voxel_value,
  input  vne_pkg::extents_t           ext,
  input  logic                        q_full,
  output logic                        q_push,
  output vne_pkg::cmd_t               q_cmd
);
  import vne_pkg::*;

  logic outside;

  // A center at or beyond any extent gives a single flagged result.
  assign outside = ({1'b0, in_pos_x} >= ext.x) ||
                   ({1'b0, in_pos_y} >= ext.y) ||
                   ({1'b0, in_pos_z} >= ext.z);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.x     = in_pos_x;
    q_cmd.y     = in_pos_y;
    q_cmd.z     = in_pos_z;
    q_cmd.value = in_voxel_value;
    if (op_t'(in_operation) == OP_WRITE) begin
      q_cmd.kind = CMD_WRITE;
    end else if (outside) begin
      q_cmd.kind = CMD_OUTSIDE;
    end else begin
      q_cmd.kind = CMD_QUERY;
    end
  end

endmodule

// File: rtl/core/vne_cmd_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on vne_pkg.
module vne_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vne_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          head_valid,
  output vne_pkg::cmd_t head_cmd,
  input  logic          pop
);
  import vne_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/core/vne_back.sv
// Back end: owns the voxel memory, performs writes, sequences the 26
// neighbor reads of a query and buffers results. Depends on vne_pkg.
module vne_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  vne_pkg::extents_t         ext,
  input  logic                      cmd_valid,
  input  vne_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [vne_pkg::VAL_W-1:0] out_neighbor_value,
  output logic [vne_pkg::IDX_W-1:0] out_neighbor_index,
  output logic                      out_last,
  output logic                      out_out_of_range
);
  import vne_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE  = 1'b0,
    ST_QUERY = 1'b1
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [COORD_W-1:0] cx_r, cy_r, cz_r;
  logic [COORD_W-1:0] cx_nxt, cy_nxt, cz_nxt;

  logic [VAL_W-1:0]   mem [STORE_DEPTH];
  logic [VAL_W-1:0]   mem_q_r;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_addr;

  // Read stage: travels alongside the memory read.
  logic               rd_vld_r;
  logic               rd_zero_r, rd_last_r, rd_oor_r;
  logic [IDX_W-1:0]   rd_idx_r;

  result_t            oq_r [2];
  logic               oq_wr_r, oq_rd_r;
  logic [1:0]         oq_cnt_r;
  logic               oq_pop;
  logic [2:0]         occupancy;
  logic               credit;

  offset_t            offs;
  logic [EXT_W-1:0]   nx, ny, nz;
  logic               nbr_inside;
  logic               issue;
  logic               issue_zero, issue_last, issue_oor;
  logic [IDX_W-1:0]   issue_idx;
  result_t            push_res;

  // Neighbor coordinates; a step below zero wraps high and fails the compare.
  always_comb begin
    offs       = NBR_OFFSETS[k_r];
    nx         = {1'b0, cx_r} + {{(EXT_W-2){1'b0}}, offs.dx} - EXT_W'(1);
    ny         = {1'b0, cy_r} + {{(EXT_W-2){1'b0}}, offs.dy} - EXT_W'(1);
    nz         = {1'b0, cz_r} + {{(EXT_W-2){1'b0}}, offs.dz} - EXT_W'(1);
    nbr_inside = (nx < ext.x) && (ny < ext.y) && (nz < ext.z);
  end

  assign oq_pop    = out_valid && out_ready;
  assign occupancy = {1'b0, oq_cnt_r} + {2'b0, rd_vld_r} - {2'b0, oq_pop};
  assign credit    = (occupancy < 3'd2);

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    cz_nxt     = cz_r;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = {cmd.z, cmd.y, cmd.x};
    issue      = 1'b0;
    issue_zero = 1'b1;
    issue_idx  = '0;
    issue_last = 1'b1;
    issue_oor  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_WRITE: begin
              cmd_pop = 1'b1;
              mem_we  = 1'b1;
            end
            CMD_QUERY: begin
              cmd_pop   = 1'b1;
              cx_nxt    = cmd.x;
              cy_nxt    = cmd.y;
              cz_nxt    = cmd.z;
              k_nxt     = '0;
              state_nxt = ST_QUERY;
            end
            CMD_OUTSIDE: begin
              cmd_pop = credit;
              issue   = credit;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_QUERY: begin
        mem_addr   = {nz[COORD_W-1:0], ny[COORD_W-1:0], nx[COORD_W-1:0]};
        issue      = credit;
        mem_re     = credit && nbr_inside;
        issue_zero = !nbr_inside;
        issue_idx  = k_r;
        issue_last = (k_r == IDX_W'(NBR_COUNT - 1));
        issue_oor  = 1'b0;
        if (credit) begin
          k_nxt = k_r + IDX_W'(1);
          if (issue_last) begin
            k_nxt     = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      k_r      <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      rd_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    cz_r      <= cz_nxt;
    rd_zero_r <= issue_zero;
    rd_idx_r  <= issue_idx;
    rd_last_r <= issue_last;
    rd_oor_r  <= issue_oor;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= cmd.value;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  // Output queue: credit above keeps it from ever overflowing.
  always_comb begin
    push_res.value = rd_zero_r ? '0 : mem_q_r;
    push_res.index = rd_idx_r;
    push_res.last  = rd_last_r;
    push_res.oor   = rd_oor_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      oq_wr_r  <= rd_vld_r ? !oq_wr_r : oq_wr_r;
      oq_rd_r  <= oq_pop ? !oq_rd_r : oq_rd_r;
      oq_cnt_r <= oq_cnt_r + {1'b0, rd_vld_r} - {1'b0, oq_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      oq_r[oq_wr_r] <= push_res;
    end
  end

  assign out_valid          = (oq_cnt_r != 2'd0);
  assign out_neighbor_value = oq_r[oq_rd_r].value;
  assign out_neighbor_index = oq_r[oq_rd_r].index;
  assign out_last           = oq_r[oq_rd_r].last;
  assign out_out_of_range   = oq_r[oq_rd_r].oor;

endmodule

// File: rtl/core/volume_neighborhood_extract.sv
// Top level of the 3D neighborhood extractor: configuration registers,
// front end, command queue and back end. Depends on vne_pkg and all vne_ modules.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    operation, pos_x/y/z, voxel_value
//   out_     output     out_valid/out_ready  neighbor_value/index, last, out_of_range
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data (extent x/y/z)
//
// A write, or a query outside the extents, is handled by the back end in its idle state.
// A query inside the extents first loads the center, then makes 26 neighbor reads through
// the single memory port, one per cycle while the result buffer has room. rst_n is
// synchronous, active low; it clears control state and sets every extent to 32.
// A stalled output fills the result buffer, then a full command queue drops in_ready.
module volume_neighborhood_extract (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic [vne_pkg::COORD_W-1:0]     in_pos_x,
  input  logic [vne_pkg::COORD_W-1:0]     in_pos_y,
  input  logic [vne_pkg::COORD_W-1:0]     in_pos_z,
  input  logic [vne_pkg::VAL_W-1:0]       in_voxel_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [vne_pkg::VAL_W-1:0]       out_neighbor_value,
  output logic [vne_pkg::IDX_W-1:0]       out_neighbor_index,
  output logic                            out_last,
  output logic                            out_out_of_range,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vne_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vne_pkg::EXT_W-1:0]       cfg_data
);
  import vne_pkg::*;

  logic [EXT_W-1:0] ext_x_r, ext_y_r, ext_z_r;
  extents_t         ext;
  logic             q_push, q_full, q_valid, q_pop;
  cmd_t             q_in_cmd, q_head_cmd;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_x_r <= EXT_W'(MAX_DIM);
      ext_y_r <= EXT_W'(MAX_DIM);
      ext_z_r <= EXT_W'(MAX_DIM);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_EXTENT_X: ext_x_r <= cfg_data;
        CFG_EXTENT_Y: ext_y_r <= cfg_data;
        CFG_EXTENT_Z: ext_z_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Extents above the store size behave as the store size.
  always_comb begin
    ext.x = (ext_x_r > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : ext_x_r;
    ext.y = (ext_y_r > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : ext_y_r;
    ext.z = (ext_z_r > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : ext_z_r;
  end

  vne_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_voxel_value (in_voxel_value),
    .ext            (ext),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_in_cmd)
  );

  vne_cmd_queue u_cmd_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_in_cmd),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop)
  );

  vne_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .ext                (ext),
    .cmd_valid          (q_valid),
    .cmd                (q_head_cmd),
    .cmd_pop            (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_neighbor_value (out_neighbor_value),
    .out_neighbor_index (out_neighbor_index),
    .out_last           (out_last),
    .out_out_of_range   (out_out_of_range)
  );

`ifndef ASSERT_OFF
  // A flagged center gives exactly one zero result at index zero.
  a_oor_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |->
      out_last && (out_neighbor_index == '0) && (out_neighbor_value == '0))
    else $error("out-of-range result is malformed");

  // The last marker of a normal query falls only on the final neighbor.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |->
      (out_last == (out_neighbor_index == IDX_W'(NBR_COUNT - 1))))
    else $error("last flag does not match neighbor index");

  // The neighbor index never passes the end of the neighborhood.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_neighbor_index <= IDX_W'(NBR_COUNT - 1)))
    else $error("neighbor index out of range");
`endif

endmodule
